/* sv/wrs_pkg.sv */
// Shared constants for the weighted random selector.
`default_nettype none

package wrs_pkg;

   // Command codes carried by an input item.
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SELECT = 1'b1;

   // Fixed field widths of the ports.
   localparam int RND_BITS       = 32;
   localparam int IDX_BITS       = 7;
   localparam int COUNT_BITS     = 8;
   localparam int WEIGHT_IN_BITS = 16;

endpackage

`default_nettype wire

/* sv/wrs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module wrs_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/wrs_mod.sv */
// Bit-serial restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module wrs_mod #(
   parameter int DIV_BITS = 23
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [wrs_pkg::RND_BITS-1:0]  dividend,
   input  wire logic [DIV_BITS-1:0]           divisor,
   output logic                               done,
   output logic      [DIV_BITS-1:0]           remainder
);

   localparam int STEP_BITS = $clog2(wrs_pkg::RND_BITS);

   logic                          run_ff,  run_in;
   logic                          done_ff, done_in;
   logic [STEP_BITS-1:0]          step_ff, step_in;
   logic [wrs_pkg::RND_BITS-1:0]  shift_ff, shift_in;
   logic [DIV_BITS-1:0]           div_ff, div_in;
   logic [DIV_BITS-1:0]           rem_ff, rem_in;
   logic [DIV_BITS:0]             trial;
   logic [DIV_BITS:0]             diff;

   assign trial = {rem_ff, shift_ff[wrs_pkg::RND_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      shift_in = shift_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      if (start) begin
         run_in   = 1'b1;
         step_in  = '0;
         shift_in = dividend;
         div_in   = divisor;
         rem_in   = '0;
      end else if (run_ff) begin
         shift_in = shift_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = diff[DIV_BITS-1:0];
         end else begin
            rem_in = trial[DIV_BITS-1:0];
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_BITS'(wrs_pkg::RND_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff  <= step_in;
      shift_ff <= shift_in;
      div_ff   <= div_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* sv/weighted_random_selector.sv */
// Top level of the weighted random selector: sequencer, weight table and total.
// A write passes through S_WRITE; a select runs the serial remainder in S_MOD and then
// scans with one table read per entry scanned, ending early on a hit; a select with
// a zero enabled total answers without a scan. Count writes rescan the table.
// Throughput: one item at a time; busy stays high until the item is finished.
// Reset clears control state and then sweeps the table to zero, one entry per cycle,
// over all MAX_SERVERS entries with busy high. Results are one-cycle strobes; no stall.
`default_nettype none

module weighted_random_selector #(
   parameter int MAX_SERVERS = 128,
   parameter int WEIGHT_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_command,
   input  wire logic [wrs_pkg::IDX_BITS-1:0]        req_entry_index,
   input  wire logic [wrs_pkg::WEIGHT_IN_BITS-1:0]  req_entry_weight,
   input  wire logic                                req_entry_enabled,
   input  wire logic [wrs_pkg::RND_BITS-1:0]        req_random_value,
   output logic                                     rsp_valid,
   output logic      [wrs_pkg::IDX_BITS-1:0]        rsp_selected_index,
   output logic                                     rsp_found,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [wrs_pkg::COUNT_BITS-1:0]      csr_server_count
);

   // Address, count and total widths all follow from the table shape.
   localparam int AW = $clog2(MAX_SERVERS);
   localparam int CW = $clog2(MAX_SERVERS + 1);
   localparam int TB = WEIGHT_BITS + AW;
   localparam int WW = WEIGHT_BITS + 1;
   localparam int RESET_COUNT = (MAX_SERVERS < 128) ? MAX_SERVERS : 128;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_MOD   = 3'd3;
   localparam logic [2:0] S_SCAN  = 3'd4;
   localparam logic [2:0] S_SUM   = 3'd5;

   logic [2:0]               state_ff,   state_in;
   logic [CW-1:0]            cnt_ff,     cnt_in;
   logic [CW-1:0]            used_ff,    used_in;
   logic [TB-1:0]            total_ff,   total_in;
   logic [TB-1:0]            cum_ff,     cum_in;
   logic                     rd_vld_ff,  rd_vld_in;
   logic [AW-1:0]            rd_idx_ff,  rd_idx_in;
   logic [AW-1:0]            wr_idx_ff,  wr_idx_in;
   logic [WW-1:0]            wr_word_ff, wr_word_in;
   logic                     in_rng_ff,  in_rng_in;
   logic                     rsp_vld_ff, rsp_vld_in;
   logic                     found_ff,   found_in;
   logic [wrs_pkg::IDX_BITS-1:0] sel_ff, sel_in;

   // Table port signals.
   logic                     ram_we;
   logic [AW-1:0]            ram_waddr;
   logic [WW-1:0]            ram_wdata;
   logic [AW-1:0]            ram_raddr;
   logic [WW-1:0]            ram_rdata;

   logic                     rd_en;
   logic [WEIGHT_BITS-1:0]   rd_w;
   logic [TB-1:0]            rd_term;
   logic [TB-1:0]            cum_next;
   logic [TB-1:0]            residue;
   logic                     accept;
   logic                     csr_fire;
   logic                     issue;
   logic                     scan_end;
   logic                     mod_start;
   logic                     mod_done;

   assign accept   = start && (state_ff == S_IDLE);
   assign csr_fire = csr_valid && csr_ready;

   // The table word holds the enabled mark above the weight.
   assign rd_en    = ram_rdata[WW-1];
   assign rd_w     = ram_rdata[WEIGHT_BITS-1:0];
   assign rd_term  = rd_en ? TB'(rd_w) : '0;
   assign cum_next = cum_ff + rd_term;

   // During a scan one entry is requested per cycle until the count in use is reached.
   // Read data arrives in the following cycle, tagged by rd_vld_ff and rd_idx_ff.
   assign issue    = (cnt_ff < used_ff);
   assign scan_end = !rd_vld_ff && !issue;

   wrs_mod #(
      .DIV_BITS (TB)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (req_random_value),
      .divisor   (total_ff),
      .done      (mod_done),
      .remainder (residue)
   );

   wrs_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_SERVERS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      used_in    = used_ff;
      total_in   = total_ff;
      cum_in     = cum_ff;
      rd_vld_in  = 1'b0;
      rd_idx_in  = cnt_ff[AW-1:0];
      wr_idx_in  = wr_idx_ff;
      wr_word_in = wr_word_ff;
      in_rng_in  = in_rng_ff;
      rsp_vld_in = 1'b0;
      found_in   = found_ff;
      sel_in     = sel_ff;
      ram_we     = 1'b0;
      ram_waddr  = cnt_ff[AW-1:0];
      ram_wdata  = '0;
      ram_raddr  = cnt_ff[AW-1:0];
      mod_start  = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            // Sweep the table to zero after reset; the total is already zero.
            ram_we = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(MAX_SERVERS - 1)) begin
               state_in = S_IDLE;
            end
            if (csr_fire) begin
               used_in = (32'(csr_server_count) > 32'(MAX_SERVERS)) ?
                         CW'(MAX_SERVERS) : CW'(csr_server_count);
            end
         end
         S_IDLE: begin
            ram_raddr = AW'(req_entry_index);
            cnt_in    = '0;
            cum_in    = '0;
            if (csr_fire) begin
               // A new count changes which entries add to the total: rescan.
               used_in  = (32'(csr_server_count) > 32'(MAX_SERVERS)) ?
                          CW'(MAX_SERVERS) : CW'(csr_server_count);
               state_in = S_SUM;
            end else if (accept) begin
               if (req_command == wrs_pkg::CMD_WRITE) begin
                  // An entry beyond the table is dropped without effect.
                  if (32'(req_entry_index) < 32'(MAX_SERVERS)) begin
                     wr_idx_in  = AW'(req_entry_index);
                     wr_word_in = {req_entry_enabled, WEIGHT_BITS'(req_entry_weight)};
                     in_rng_in  = (32'(req_entry_index) < 32'(used_ff));
                     state_in   = S_WRITE;
                  end
               end else if (total_ff == '0) begin
                  // Nothing enabled in range: answer not found at once.
                  rsp_vld_in = 1'b1;
                  found_in   = 1'b0;
                  sel_in     = '0;
               end else begin
                  mod_start = 1'b1;
                  state_in  = S_MOD;
               end
            end
         end
         S_WRITE: begin
            // The old entry is on the read port now; swap its share of the total.
            if (in_rng_ff) begin
               total_in = total_ff - rd_term
                        + (wr_word_ff[WW-1] ? TB'(wr_word_ff[WEIGHT_BITS-1:0]) : TB'(0));
            end
            ram_we    = 1'b1;
            ram_waddr = wr_idx_ff;
            ram_wdata = wr_word_ff;
            state_in  = S_IDLE;
         end
         S_MOD: begin
            cnt_in = '0;
            cum_in = '0;
            if (mod_done) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN, S_SUM: begin
            if (issue) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               cum_in = cum_next;
            end
            if (state_ff == S_SCAN) begin
               // The running sum stays at or below the residue until the pick,
               // so a zero-weight entry can never be the first to exceed it.
               if (rd_vld_ff && (cum_next > residue)) begin
                  rsp_vld_in = 1'b1;
                  found_in   = 1'b1;
                  sel_in     = wrs_pkg::IDX_BITS'(rd_idx_ff);
                  state_in   = S_IDLE;
               end else if (scan_end) begin
                  rsp_vld_in = 1'b1;
                  found_in   = 1'b0;
                  sel_in     = '0;
                  state_in   = S_IDLE;
               end
            end else if (scan_end) begin
               total_in = cum_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         cnt_ff     <= '0;
         used_ff    <= CW'(RESET_COUNT);
         total_ff   <= '0;
         rd_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         used_ff    <= used_in;
         total_ff   <= total_in;
         rd_vld_ff  <= rd_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      cum_ff     <= cum_in;
      rd_idx_ff  <= rd_idx_in;
      wr_idx_ff  <= wr_idx_in;
      wr_word_ff <= wr_word_in;
      in_rng_ff  <= in_rng_in;
      found_ff   <= found_in;
      sel_ff     <= sel_in;
   end

   // A count write is taken during the sweep or when idle, but never in the
   // same cycle as an accepted item.
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_CLEAR) || ((state_ff == S_IDLE) && !start);

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_found          = found_ff;
   assign rsp_selected_index = sel_ff;

endmodule

`default_nettype wire

/* sv/wrs_checker.sv */
// Port-level assertions for the weighted random selector, bound to the top level.
`default_nettype none

module wrs_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire logic                          req_command,
   input wire logic                          rsp_valid,
   input wire logic [wrs_pkg::IDX_BITS-1:0]  rsp_selected_index,
   input wire logic                          rsp_found,
   input wire logic                          csr_valid,
   input wire logic                          csr_ready
);

   // Coming out of reset the table sweep keeps the block busy.
   a_sweep_busy: assert property (@(posedge clock) $fell(reset) |-> busy)
      else $error("block not busy during table sweep");

   // A result only follows an item in progress or one just accepted.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) || $past(start)))
      else $error("result with no item in progress");

   // A not-found result carries index zero.
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_selected_index == '0))
      else $error("not-found result with nonzero index");

   // A write item produces no result.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_command == wrs_pkg::CMD_WRITE)) |=> !rsp_valid)
      else $error("result after a write item");

   // A count write never lands together with an accepted item.
   a_csr_excl: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !(start && !busy))
      else $error("count write collides with an item");

endmodule

bind weighted_random_selector wrs_checker u_wrs_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_command        (req_command),
   .rsp_valid          (rsp_valid),
   .rsp_selected_index (rsp_selected_index),
   .rsp_found          (rsp_found),
   .csr_valid          (csr_valid),
   .csr_ready          (csr_ready)
);

`default_nettype wire

/* test/wrs_checker.sv */
// Checker for the weighted random selector: shadow table, selection predictor and result compare.
module wrs_tb_checker #(
   parameter int MAX_SERVERS = 128
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic                                busy,
   input  wire logic                                req_command,
   input  wire logic [wrs_pkg::IDX_BITS-1:0]        req_entry_index,
   input  wire logic [wrs_pkg::WEIGHT_IN_BITS-1:0]  req_entry_weight,
   input  wire logic                                req_entry_enabled,
   input  wire logic [wrs_pkg::RND_BITS-1:0]        req_random_value,
   input  wire logic                                rsp_valid,
   input  wire logic [wrs_pkg::IDX_BITS-1:0]        rsp_selected_index,
   input  wire logic                                rsp_found,
   input  wire logic                                csr_valid,
   input  wire logic                                csr_ready,
   input  wire logic [wrs_pkg::COUNT_BITS-1:0]      csr_server_count,
   output int                                       error_count,
   output int                                       pending_count
);

   typedef struct packed {
      logic [wrs_pkg::IDX_BITS-1:0] index;
      logic                         found;
   } pick_type;

   logic [wrs_pkg::WEIGHT_IN_BITS-1:0] weight_mem [MAX_SERVERS];
   logic                               enable_mem [MAX_SERVERS];
   logic [22:0]                        enabled_sum;
   logic [wrs_pkg::COUNT_BITS-1:0]     server_count;
   pick_type                           pending_picks [$];
   int                                 mismatches = 0;

   function automatic int entries_in_use();
      return (server_count > MAX_SERVERS) ? MAX_SERVERS : int'(server_count);
   endfunction

   function automatic logic [22:0] sum_enabled_weights();
      logic [22:0] acc;
      acc = '0;
      for (int i = 0; i < entries_in_use(); i++) begin
         if (enable_mem[i]) begin
            acc += weight_mem[i];
         end
      end
      return acc;
   endfunction

   // The running sum only tracks entries inside the scanned range.
   function automatic void note_entry_write(input logic [wrs_pkg::IDX_BITS-1:0] idx,
                                            input logic [wrs_pkg::WEIGHT_IN_BITS-1:0] weight,
                                            input logic enabled);
      if (int'(idx) < entries_in_use()) begin
         if (enable_mem[idx]) begin
            enabled_sum -= weight_mem[idx];
         end
         if (enabled) begin
            enabled_sum += weight;
         end
      end
      weight_mem[idx] = weight;
      enable_mem[idx] = enabled;
   endfunction

   // First enabled entry whose cumulative weight passes the residue wins.
   function automatic pick_type predict_selection(input logic [wrs_pkg::RND_BITS-1:0] rnd);
      pick_type    pick;
      logic [31:0] residue;
      logic [31:0] running;
      pick    = '0;
      running = '0;
      if (enabled_sum != 0) begin
         residue = rnd % {9'd0, enabled_sum};
         for (int i = 0; i < entries_in_use() && !pick.found; i++) begin
            if (enable_mem[i]) begin
               running += weight_mem[i];
               if (running > residue) begin
                  pick.index = wrs_pkg::IDX_BITS'(i);
                  pick.found = 1'b1;
               end
            end
         end
      end
      return pick;
   endfunction

   always @(posedge clock) begin
      pick_type got;
      pick_type want;
      if (reset) begin
         for (int i = 0; i < MAX_SERVERS; i++) begin
            weight_mem[i] = '0;
            enable_mem[i] = 1'b0;
         end
         enabled_sum  = '0;
         server_count = 8'd128;
         pending_picks.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            server_count = csr_server_count;
            enabled_sum  = sum_enabled_weights();
         end
         // A result always belongs to an item accepted earlier, so pop before push.
         if (rsp_valid) begin
            got.index = rsp_selected_index;
            got.found = rsp_found;
            if (pending_picks.size() == 0) begin
               $display("%0t wrs_checker: result with none expected, index %0d found %0d",
                        $time, got.index, got.found);
               mismatches++;
            end else begin
               want = pending_picks.pop_front();
               if (got.found !== want.found) begin
                  $display("%0t wrs_checker: found expected %0d actual %0d",
                           $time, want.found, got.found);
                  mismatches++;
               end
               if (got.index !== want.index) begin
                  $display("%0t wrs_checker: selected_index expected %0d actual %0d",
                           $time, want.index, got.index);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            if (req_command == wrs_pkg::CMD_SELECT) begin
               pending_picks.push_back(predict_selection(req_random_value));
            end else begin
               note_entry_write(req_entry_index, req_entry_weight, req_entry_enabled);
            end
         end
      end
      pending_count <= pending_picks.size();
      error_count   <= mismatches;
   end

endmodule

/* test/tb_top.sv */
// Top of the weighted random selector testbench: clock, reset, item stimulus and verdict.
module tb_top;

   // Longest stretch without any accepted item, result or register write. The slowest
   // legitimate stretch is the longest sender gap on top of a full scan or a count
   // rescan, so this leaves a wide margin.
   localparam int IDLE_LIMIT      = 4000;
   // Quiet time after the last expected result, a little more than a full select.
   localparam int DRAIN_CYCLES    = 200;
   localparam int ITEMS_PER_PHASE = 165;
   localparam int PHASES          = 10;

   logic                               clock             = 1'b0;
   logic                               reset             = 1'b1;
   logic                               start             = 1'b0;
   logic                               req_command       = wrs_pkg::CMD_WRITE;
   logic [wrs_pkg::IDX_BITS-1:0]       req_entry_index   = '0;
   logic [wrs_pkg::WEIGHT_IN_BITS-1:0] req_entry_weight  = '0;
   logic                               req_entry_enabled = 1'b0;
   logic [wrs_pkg::RND_BITS-1:0]       req_random_value  = '0;
   logic                               csr_valid         = 1'b0;
   logic [wrs_pkg::COUNT_BITS-1:0]     csr_server_count  = '0;

   logic                               busy;
   logic                               rsp_valid;
   logic [wrs_pkg::IDX_BITS-1:0]       rsp_selected_index;
   logic                               rsp_found;
   logic                               csr_ready;

   int error_count;
   int pending_count;
   int burst_left  = 0;
   int idle_cycles = 0;

   always #10 clock = ~clock;

   weighted_random_selector u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_entry_index    (req_entry_index),
      .req_entry_weight   (req_entry_weight),
      .req_entry_enabled  (req_entry_enabled),
      .req_random_value   (req_random_value),
      .rsp_valid          (rsp_valid),
      .rsp_selected_index (rsp_selected_index),
      .rsp_found          (rsp_found),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_server_count   (csr_server_count)
   );

   // The checker sits beside the block and sees the same pins. It owns all
   // prediction; this module only makes stimulus and reads back two counters.
   wrs_tb_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_entry_index    (req_entry_index),
      .req_entry_weight   (req_entry_weight),
      .req_entry_enabled  (req_entry_enabled),
      .req_random_value   (req_random_value),
      .rsp_valid          (rsp_valid),
      .rsp_selected_index (rsp_selected_index),
      .rsp_found          (rsp_found),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_server_count   (csr_server_count),
      .error_count        (error_count),
      .pending_count      (pending_count)
   );

   // Watchdog: any handshake on any channel counts as progress. A hang in the
   // sequencer or a lost result shows up as a long run of idle cycles.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Drops start and waits until every expected result is back and the block is
   // idle. The first clock is taken unconditionally so that the checker's count
   // already includes an item accepted at the current edge.
   task automatic wait_until_drained();
      if (start) begin
         start <= 1'b0;
      end
      do @(posedge clock); while (pending_count != 0 || busy);
   endtask

   // Presents one item and holds it until the block takes it. The sender works in
   // bursts: between bursts it lowers start for a random gap, which may be short
   // enough to land while the block is still scanning or long enough to leave it
   // idle. Within a burst start simply stays high from item to item.
   task automatic issue_item(input logic cmd, input logic [wrs_pkg::IDX_BITS-1:0] idx,
                             input logic [wrs_pkg::WEIGHT_IN_BITS-1:0] weight,
                             input logic enabled,
                             input logic [wrs_pkg::RND_BITS-1:0] rnd);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 24);
      end
      burst_left--;
      if (gap > 0) begin
         if (start) begin
            start <= 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_command       <= cmd;
      req_entry_index   <= idx;
      req_entry_weight  <= weight;
      req_entry_enabled <= enabled;
      req_random_value  <= rnd;
      start             <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // The count register is only touched with the block idle. A table write
   // produces no result, so the spare wait after the drain covers one still in progress.
   task automatic program_server_count(input logic [wrs_pkg::COUNT_BITS-1:0] count);
      wait_until_drained();
      repeat (4) @(posedge clock);
      csr_server_count <= count;
      csr_valid        <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One random item. Writes mostly land inside the scanned range so that the
   // enabled sum grows and selects exercise real scans; the rest go anywhere in
   // the table. Weights favor zero, all ones and small values, where the
   // cumulative compare is most sensitive. Now and then the sender stops until
   // every outstanding result has come back.
   task automatic issue_random_item(input int used);
      logic                               cmd;
      logic [wrs_pkg::IDX_BITS-1:0]       idx;
      logic [wrs_pkg::WEIGHT_IN_BITS-1:0] weight;
      logic                               enabled;
      logic [wrs_pkg::RND_BITS-1:0]       rnd;
      cmd = ($urandom_range(0, 99) < 45) ? wrs_pkg::CMD_WRITE : wrs_pkg::CMD_SELECT;
      if (used > 0 && $urandom_range(0, 4) != 0) begin
         idx = wrs_pkg::IDX_BITS'($urandom_range(0, used - 1));
      end else begin
         idx = wrs_pkg::IDX_BITS'($urandom_range(0, 127));
      end
      case ($urandom_range(0, 7))
         0: begin
            weight = '0;
         end
         1: begin
            weight = '1;
         end
         2, 3: begin
            weight = wrs_pkg::WEIGHT_IN_BITS'($urandom_range(0, 15));
         end
         4: begin
            weight = wrs_pkg::WEIGHT_IN_BITS'($urandom_range(0, 255));
         end
         default: begin
            weight = wrs_pkg::WEIGHT_IN_BITS'($urandom);
         end
      endcase
      enabled = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 7))
         0: begin
            rnd = wrs_pkg::RND_BITS'($urandom_range(0, 1023));
         end
         1: begin
            rnd = '1;
         end
         default: begin
            rnd = $urandom;
         end
      endcase
      issue_item(cmd, idx, weight, enabled, rnd);
      if ($urandom_range(0, 59) == 0) begin
         wait_until_drained();
      end
   endtask

   initial begin
      logic [wrs_pkg::COUNT_BITS-1:0] phase_counts [PHASES];
      int                             used;
      // Count settings for the random phases: full table, the two smallest ranges, zero,
      // values past the table (all ones, and just over), two random ones, 64 and 128.
      phase_counts = '{8'd128, 8'd2, 8'd255, 8'd1, 8'd0, 8'd129, 8'd0, 8'd0, 8'd64, 8'd128};
      phase_counts[6] = wrs_pkg::COUNT_BITS'($urandom_range(3, 127));
      phase_counts[7] = wrs_pkg::COUNT_BITS'($urandom_range(3, 127));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The block comes out of reset with all 128 entries in use and
      // an empty table, so the first selects hit the zero-sum case.
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h0000_0000);
      // An enabled entry of weight zero must never be chosen, and keeps the sum at zero.
      issue_item(wrs_pkg::CMD_WRITE,  7'd0,   16'h0000, 1'b1, 32'h0000_0000);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'hFFFF_FFFF);
      issue_item(wrs_pkg::CMD_WRITE,  7'd127, 16'hFFFF, 1'b1, 32'h0000_0000);
      issue_item(wrs_pkg::CMD_WRITE,  7'd5,   16'h0001, 1'b1, 32'h0000_0000);
      issue_item(wrs_pkg::CMD_WRITE,  7'd6,   16'h8000, 1'b0, 32'h0000_0000);
      // A residue of zero lands on the weight-one entry, whatever the upper bits;
      // any other residue falls on the last entry.
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h0000_0000);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h0000_0001);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'hFFFF_FFFF);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h0001_0000);
      // Disable one entry, enable another and overwrite a third, all in range.
      issue_item(wrs_pkg::CMD_WRITE,  7'd5,   16'h0001, 1'b0, 32'h0000_0000);
      issue_item(wrs_pkg::CMD_WRITE,  7'd6,   16'h8000, 1'b1, 32'h0000_0000);
      issue_item(wrs_pkg::CMD_WRITE,  7'd127, 16'hAAAA, 1'b1, 32'h0000_0000);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h5555_5555);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h0000_7FFF);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h0000_8000);

      // With a count of zero nothing is scanned, and a write only touches the table.
      program_server_count(8'd0);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h0000_007B);
      issue_item(wrs_pkg::CMD_WRITE,  7'd3,   16'h1234, 1'b1, 32'h0000_0000);

      // A count past the table acts as the full table, so the entry written above counts.
      program_server_count(8'd255);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h0000_1234);

      // Only entry zero in range: it has weight zero until rewritten, then always wins.
      // A write beyond the range must leave the sum alone.
      program_server_count(8'd1);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h0000_0007);
      issue_item(wrs_pkg::CMD_WRITE,  7'd0,   16'h0007, 1'b1, 32'h0000_0000);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'hFFFF_FFFF);
      issue_item(wrs_pkg::CMD_WRITE,  7'd10,  16'h0064, 1'b1, 32'h0000_0000);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h0000_0009);

      // Growing the range again must pull the out-of-range writes into the sum.
      program_server_count(8'd128);
      issue_item(wrs_pkg::CMD_SELECT, 7'd0,   16'h0000, 1'b0, 32'h0000_0003);

      // Random phases, each under its own count setting.
      for (int p = 0; p < PHASES; p++) begin
         program_server_count(phase_counts[p]);
         used = (phase_counts[p] > 8'd128) ? 128 : int'(phase_counts[p]);
         repeat (ITEMS_PER_PHASE) issue_random_item(used);
      end

      // Wait for every outstanding result, then give any stray strobe time to show.
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

/* weighted_random_selector.f */
sv/wrs_pkg.sv
sv/wrs_ram.sv
sv/wrs_mod.sv
sv/weighted_random_selector.sv
sv/wrs_checker.sv
test/wrs_checker.sv
test/tb_top.sv
